FILE: design/bit_stream_realigning_copy_assert.svh
`ifndef BIT_STREAM_REALIGNING_COPY_ASSERT_SVH
`define BIT_STREAM_REALIGNING_COPY_ASSERT_SVH

// Condition holds on every clock edge outside reset.
`define BSRC_ASSERT_HOLDS(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("assertion failed");

// Trigger in one cycle implies the outcome in the next.
`define BSRC_ASSERT_NEXT(lbl, ck, rn, trig, outcome) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (outcome)) \
    else $error("assertion failed");

`endif

FILE: design/bsrc_pkg.sv
package bsrc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int OFS_W         = 5;
  localparam int BCNT_W        = 20;
  localparam int REM_W         = 22;
  localparam int CFG_IDX_W     = 2;
  localparam int OFIFO_DEPTH   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_OFS = 2'd0,
    CFG_DST_OFS = 2'd1,
    CFG_BIT_CNT = 2'd2
  } cfg_reg_t;

  // Result words produced by one source transaction.
  typedef struct packed {
    logic first;
    logic second;
    logic last_first;
    logic last_second;
  } bsrc_push_t;

  // Offset modulo word size, by repeated subtraction.
  function automatic logic [OFS_W-1:0] ofs_wrap(input logic [OFS_W-1:0] v,
                                                input int unsigned wb);
    logic [OFS_W:0] r;
    r = {1'b0, v};
    for (int s = 0; s < 4; s++) begin
      if (r >= (OFS_W+1)'(wb)) begin
        r = r - (OFS_W+1)'(wb);
      end
    end
    return r[OFS_W-1:0];
  endfunction

endpackage

FILE: design/bsrc_core.sv
`include "bit_stream_realigning_copy_assert.svh"

module bsrc_core import bsrc_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BCNT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 space,
  input  logic [WORD_BITS-1:0] in_src_word,
  output logic                 in_ready,
  output bsrc_push_t           push,
  output logic [WORD_BITS-1:0] data0,
  output logic [WORD_BITS-1:0] mask0,
  output logic [WORD_BITS-1:0] data1,
  output logic [WORD_BITS-1:0] mask1
);

  localparam int SH_W  = $clog2(WORD_BITS + 1);
  localparam int VEC_W = 4 * WORD_BITS;
  localparam int OFF_W = $clog2(VEC_W) + 1;
  localparam logic signed [REM_W-1:0] WS = REM_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES = '1;

  logic [OFS_W-1:0]  so_r, so_nxt, do_r, do_nxt;
  logic [BCNT_W-1:0] cnt_r, cnt_nxt;
  logic              fresh_r, fresh_nxt, head_r, head_nxt;
  logic [1:0]        rel_r, rel_nxt;
  logic signed [REM_W-1:0] rem_r, rem_nxt, srem_r, srem_nxt;
  logic [WORD_BITS-1:0] held_r, held_nxt;

  logic fire, restart, has_cnt, dpos, src_last, cfg_hit, final_push;
  logic final1, final2, ready1, ready2, head_e;
  logic [1:0] rel_e, n_out;
  logic signed [REM_W-1:0] dend, sstart, rem_e, srem_e, rem2, rem_step;
  logic [SH_W-1:0] start1, end1, end2;
  logic [OFF_W-1:0] off1, off2;
  logic [VEC_W-1:0] vec, sh1, sh2;

  assign in_ready = space && !cfg_we;
  assign fire     = in_valid && in_ready;
  assign has_cnt  = cnt_r != '0;
  assign restart  = fresh_r || rem_r[REM_W-1] || (rem_r == '0);
  assign dend     = REM_W'(do_r) + REM_W'(cnt_r);
  assign sstart   = REM_W'(so_r) + REM_W'(cnt_r);
  assign rel_e    = restart ? 2'd1 : rel_r;
  assign rem_e    = restart ? dend : rem_r;
  assign srem_e   = restart ? sstart : srem_r;
  assign head_e   = restart || head_r;
  assign dpos     = so_r > do_r;
  assign src_last = srem_e <= WS;

  assign final1 = rem_e <= WS;
  assign ready1 = final1 ? src_last : (dpos ? (rel_e == 2'd0) : (rel_e <= 2'd1));
  assign rem2   = rem_e - WS;
  assign final2 = rem2 <= WS;
  assign ready2 = ready1 && !final1 &&
                  (final2 ? src_last : (!dpos && (rel_e == 2'd0)));
  assign n_out  = 2'(ready1) + 2'(ready2);

  assign start1 = head_e ? SH_W'(do_r) : '0;
  assign end1   = final1 ? SH_W'(rem_e) : SH_W'(WORD_BITS);
  assign end2   = final2 ? SH_W'(rem2) : SH_W'(WORD_BITS);
  assign mask0  = (ONES >> start1) & ~(ONES >> end1);
  assign mask1  = ~(ONES >> end2);

  assign off1 = OFF_W'(rel_e) * OFF_W'(WORD_BITS) + OFF_W'(WORD_BITS)
              + OFF_W'(so_r) - OFF_W'(do_r);
  assign off2 = off1 + OFF_W'(WORD_BITS);
  assign vec  = {{WORD_BITS{1'b0}}, held_r, in_src_word, {WORD_BITS{1'b0}}};
  assign sh1  = vec << off1;
  assign sh2  = vec << off2;
  assign data0 = sh1[VEC_W-1 -: WORD_BITS] & mask0;
  assign data1 = sh2[VEC_W-1 -: WORD_BITS] & mask1;

  assign cfg_hit    = cfg_we && (cfg_index == CFG_SRC_OFS || cfg_index == CFG_DST_OFS ||
                                 cfg_index == CFG_BIT_CNT);
  assign final_push = (push.first && push.last_first) || (push.second && push.last_second);

  always_comb begin
    push.first       = fire && has_cnt && ready1;
    push.second      = fire && has_cnt && ready2;
    push.last_first  = final1;
    push.last_second = final2;
  end

  always_comb begin
    so_nxt    = so_r;
    do_nxt    = do_r;
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    head_nxt  = head_r;
    rel_nxt   = rel_r;
    rem_nxt   = rem_r;
    srem_nxt  = srem_r;
    held_nxt  = held_r;
    case (n_out)
      2'd2:    rem_step = WS + WS;
      2'd1:    rem_step = WS;
      default: rem_step = '0;
    endcase
    if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_OFS: begin
          so_nxt    = ofs_wrap(cfg_wdata[OFS_W-1:0], WORD_BITS);
          fresh_nxt = 1'b1;
        end
        CFG_DST_OFS: begin
          do_nxt    = ofs_wrap(cfg_wdata[OFS_W-1:0], WORD_BITS);
          fresh_nxt = 1'b1;
        end
        CFG_BIT_CNT: begin
          cnt_nxt   = cfg_wdata;
          fresh_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (fire && has_cnt) begin
      held_nxt  = in_src_word;
      rel_nxt   = 2'({1'b0, rel_e} + {1'b0, n_out} - 3'd1);
      rem_nxt   = rem_e - rem_step;
      srem_nxt  = srem_e - WS;
      head_nxt  = head_e && !ready1;
      fresh_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r    <= '0;
      do_r    <= '0;
      cnt_r   <= BCNT_W'(1);
      fresh_r <= 1'b1;
      head_r  <= 1'b1;
      rel_r   <= 2'd1;
      rem_r   <= '0;
      srem_r  <= '0;
    end else begin
      so_r    <= so_nxt;
      do_r    <= do_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
      head_r  <= head_nxt;
      rel_r   <= rel_nxt;
      rem_r   <= rem_nxt;
      srem_r  <= srem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  `BSRC_ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_hit, fresh_r)
  `BSRC_ASSERT_NEXT(a_final_ends, clk, rst_n, final_push, rem_r[REM_W-1] || rem_r == '0)
  `BSRC_ASSERT_HOLDS(a_second_follows, clk, rst_n, !push.second || (push.first && !push.last_first))

endmodule

FILE: design/bsrc_ofifo.sv
`include "bit_stream_realigning_copy_assert.svh"

module bsrc_ofifo import bsrc_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bsrc_push_t           push,
  input  logic [WORD_BITS-1:0] data0,
  input  logic [WORD_BITS-1:0] mask0,
  input  logic [WORD_BITS-1:0] data1,
  input  logic [WORD_BITS-1:0] mask1,
  input  logic                 out_ready,
  output logic                 space,
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] out_dst_word,
  output logic [WORD_BITS-1:0] out_write_mask,
  output logic                 out_last_word
);

  localparam int DEPTH = OFIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int FC_W  = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] dat_r [DEPTH];
  logic [WORD_BITS-1:0] msk_r [DEPTH];
  logic                 lst_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [FC_W-1:0]  cnt_r, cnt_nxt;
  logic             pop;

  assign space     = cnt_r <= FC_W'(DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr_r + PTR_W'(1);

  assign out_dst_word   = dat_r[rd_ptr_r];
  assign out_write_mask = msk_r[rd_ptr_r];
  assign out_last_word  = lst_r[rd_ptr_r];

  always_comb begin
    cnt_nxt    = cnt_r + FC_W'(push.first) + FC_W'(push.second) - FC_W'(pop);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.first) + PTR_W'(push.second);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      dat_r[wr_ptr_r] <= data0;
      msk_r[wr_ptr_r] <= mask0;
      lst_r[wr_ptr_r] <= push.last_first;
    end
    if (push.second) begin
      dat_r[wr_ptr1] <= data1;
      msk_r[wr_ptr1] <= mask1;
      lst_r[wr_ptr1] <= push.last_second;
    end
  end

  `BSRC_ASSERT_HOLDS(a_cnt_bound, clk, rst_n, cnt_r <= FC_W'(DEPTH))
  `BSRC_ASSERT_HOLDS(a_pair_order, clk, rst_n, !push.second || push.first)
  `BSRC_ASSERT_NEXT(a_drain, clk, rst_n, pop && !push.first, cnt_r == $past(cnt_r) - FC_W'(1))

endmodule

FILE: design/bit_stream_realigning_copy.sv
// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    in_src_word
// out_      out  out_valid / out_ready  out_dst_word, out_write_mask, out_last_word
// cfg_      in   cfg_we                 cfg_index, cfg_wdata
//
// One source transaction per cycle while in_ready is high; each gives zero, one or two result words.
// Results enter a 4-entry queue at the accepting edge; out_valid rises in the cycle after.
// in_ready drops while more than two results are queued, and while cfg_we is high.
// Reset is synchronous; a register write restarts the transfer.
// Output stalls only back up the input through the queue.

module bit_stream_realigning_copy import bsrc_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BCNT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] in_src_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] out_dst_word,
  output logic [WORD_BITS-1:0] out_write_mask,
  output logic                 out_last_word
);

  bsrc_push_t           push;
  logic                 space;
  logic [WORD_BITS-1:0] data0, mask0, data1, mask1;

  bsrc_core #(.WORD_BITS(WORD_BITS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .space       (space),
    .in_src_word (in_src_word),
    .in_ready    (in_ready),
    .push        (push),
    .data0       (data0),
    .mask0       (mask0),
    .data1       (data1),
    .mask1       (mask1)
  );

  bsrc_ofifo #(.WORD_BITS(WORD_BITS)) u_ofifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .data0          (data0),
    .mask0          (mask0),
    .data1          (data1),
    .mask1          (mask1),
    .out_ready      (out_ready),
    .space          (space),
    .out_valid      (out_valid),
    .out_dst_word   (out_dst_word),
    .out_write_mask (out_write_mask),
    .out_last_word  (out_last_word)
  );

endmodule
